>>> src/btd_pkg.sv
// package for the block transposition decoder
// holds widths, register indexes and the controller/datapath interface types
// no dependencies
`default_nettype none

package btd_pkg;

    // block geometry
    localparam int MAX_BLOCK = 16;
    localparam int ADDR_W    = $clog2(MAX_BLOCK);
    localparam int SIZE_W    = $clog2(MAX_BLOCK + 1);
    localparam int NIB_W     = 4;
    localparam int BYTE_W    = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int BSIZE_W    = 5;
    localparam int KEY_W      = 64;

    localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(16);
    localparam logic [KEY_W-1:0]   KEY_RESET   = 64'hFEDC_BA98_7654_3210;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE = 2'd0,
        CFG_KEY_ORDER  = 2'd1
    } t_cfg_idx;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // input item taken this cycle
        logic start;     // load the pending mask for a full block
        logic emit;      // move the chosen byte into the output register
        logic rank_inc;  // no byte left at the current rank
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic block_full;     // the byte at the fill position completes a block
        logic pending_empty;  // nothing left to emit for this block
        logic cand_any;       // some pending byte has the current rank
        logic emit_last;      // the chosen byte is the last one of the block
        logic out_free;       // output register can take a byte this cycle
    } t_status;

    // clamp the block size register to 1..MAX_BLOCK
    function automatic logic [SIZE_W-1:0] eff_size(input logic [BSIZE_W-1:0] bsize);
        logic [SIZE_W-1:0] s;
        if (bsize == '0) begin
            s = SIZE_W'(1);
        end else if (BSIZE_W'(bsize) > BSIZE_W'(MAX_BLOCK)) begin
            s = SIZE_W'(MAX_BLOCK);
        end else begin
            s = SIZE_W'(bsize);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/btd_datapath.sv
// datapath of the block transposition decoder
// block store, fill counter, config registers, rank scan and output register
// depends on btd_pkg
`default_nettype none

module btd_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // config write
    input  wire                          i_cfg_we,
    input  wire  [btd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [btd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input payload
    input  wire  [btd_pkg::BYTE_W-1:0]   i_cipher_byte,
    // control
    input  btd_pkg::t_cmd                i_cmd,
    output btd_pkg::t_status             o_status,
    // output side
    input  wire                          i_out_ready,
    output logic                         o_out_valid,
    output logic [btd_pkg::BYTE_W-1:0]   o_plain_byte,
    output logic                         o_block_last
);
    import btd_pkg::*;

    logic [BYTE_W-1:0]    r_store [MAX_BLOCK];
    logic [ADDR_W-1:0]    r_fill;
    logic [BSIZE_W-1:0]   r_bsize;
    logic [KEY_W-1:0]     r_key;
    logic [MAX_BLOCK-1:0] r_pending;
    logic [NIB_W-1:0]     r_rank;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_plain;
    logic                 r_last;

    logic [SIZE_W-1:0]    size;
    logic [SIZE_W-1:0]    pos_next;
    logic [MAX_BLOCK-1:0] valid_mask;
    logic [MAX_BLOCK-1:0] cand;
    logic [MAX_BLOCK-1:0] pick_oh;
    logic [ADDR_W-1:0]    pick_idx;
    logic                 out_free;

    assign size     = eff_size(r_bsize);
    assign pos_next = SIZE_W'(r_fill) + SIZE_W'(1);

    // positions that take part in a block: inside the size, rank inside the size
    always_comb begin
        for (int z = 0; z < MAX_BLOCK; z++) begin
            valid_mask[z] = (SIZE_W'(z) < size)
                         && (SIZE_W'(r_key[NIB_W*z +: NIB_W]) < size);
            cand[z]       = r_pending[z] && (r_key[NIB_W*z +: NIB_W] == r_rank);
        end
    end

    // lowest pending position at the current rank
    assign pick_oh = cand & (~cand + MAX_BLOCK'(1));
    always_comb begin
        pick_idx = '0;
        for (int z = MAX_BLOCK - 1; z >= 0; z--) begin
            if (cand[z]) begin
                pick_idx = ADDR_W'(z);
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.block_full    = (pos_next >= size);
        o_status.pending_empty = (r_pending == '0);
        o_status.cand_any      = (cand != '0);
        o_status.emit_last     = ((r_pending & ~pick_oh) == '0);
        o_status.out_free      = out_free;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize <= BSIZE_RESET;
            r_key   <= KEY_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BLOCK_SIZE: r_bsize <= i_cfg_data[BSIZE_W-1:0];
                CFG_KEY_ORDER:  r_key   <= i_cfg_data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // block store, written at the fill position
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_store[r_fill] <= i_cipher_byte;
        end
    end

    // fill counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.accept) begin
            r_fill <= o_status.block_full ? '0 : pos_next[ADDR_W-1:0];
        end
    end

    // rank scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_rank    <= '0;
        end else if (i_cmd.start) begin
            r_pending <= valid_mask;
            r_rank    <= '0;
        end else if (i_cmd.emit) begin
            r_pending <= r_pending & ~pick_oh;
        end else if (i_cmd.rank_inc) begin
            r_rank <= r_rank + NIB_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_plain <= r_store[pick_idx];
            r_last  <= o_status.emit_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_plain_byte = r_plain;
    assign o_block_last = r_last;

endmodule

`default_nettype wire

>>> src/btd_ctrl.sv
// controller of the block transposition decoder
// fill / scan state machine driving the datapath commands
// depends on btd_pkg
`default_nettype none

module btd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  btd_pkg::t_status  i_status,
    output btd_pkg::t_cmd     o_cmd
);
    import btd_pkg::*;

    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_FILL);

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.start    = 1'b0;
        o_cmd.emit     = 1'b0;
        o_cmd.rank_inc = 1'b0;
        unique case (r_state)
            ST_FILL: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.block_full) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                priority if (i_status.pending_empty) begin
                    n_state = ST_FILL;
                end else if (i_status.cand_any) begin
                    if (i_status.out_free) begin
                        o_cmd.emit = 1'b1;
                        if (i_status.emit_last) begin
                            n_state = ST_FILL;
                        end
                    end
                end else begin
                    o_cmd.rank_inc = 1'b1;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> src/block_transposition_decoder.sv
// top level of the block transposition decoder
// instantiates btd_ctrl and btd_datapath; depends on btd_pkg
//
// usage:
//   input channel (i_in_valid / o_in_ready / i_cipher_byte) takes ciphertext
//   one byte per item. once block_size bytes are in, the block is sent on the
//   output channel (o_out_valid / i_out_ready / o_plain_byte / o_block_last)
//   in key order; o_block_last marks the final byte of the block. positions
//   whose key rank is at or above the size are dropped.
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 is block_size (1..16, 0 acts as 1), index 1 is key_order; write
//   only while the block is idle. o_cfg_ready is always high.
// timing:
//   bytes of a block are taken one per cycle. after the completing byte the
//   input is held off while the rank scan runs, which emits the bytes in
//   rank order and steps over each empty rank before the last filled rank;
//   with nothing to emit it goes back to filling. the first byte reaches
//   the output register after any empty ranks before its own rank.
//   the scan walks ranks with one priority pick over the 16 positions a
//   cycle while the output is free.
// reset: synchronous, active low; clears the fill count, the output valid flag
//   and restores block_size = 16 and the identity key.
// stall: a stalled output holds its byte and stops the scan at the next byte;
//   the last byte of a block may wait in the output register while the next
//   block fills.
`default_nettype none

module block_transposition_decoder (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // input channel
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [btd_pkg::BYTE_W-1:0]      i_cipher_byte,
    // output channel
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [btd_pkg::BYTE_W-1:0]      o_plain_byte,
    output logic                            o_block_last,
    // config channel
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [btd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [btd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import btd_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    // control
    btd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    btd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cipher_byte (i_cipher_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_plain_byte  (o_plain_byte),
        .o_block_last  (o_block_last)
    );

endmodule

`default_nettype wire

>>> src/btd_checker.sv
// port-level checks for the block transposition decoder
// bound to block_transposition_decoder; depends on btd_pkg
`default_nettype none

module btd_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_valid,
    input wire                        o_in_ready,
    input wire                        o_out_valid,
    input wire                        i_out_ready,
    input wire [btd_pkg::BYTE_W-1:0]  o_plain_byte,
    input wire                        o_block_last
);
    import btd_pkg::*;

    // a stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_plain_byte) && $stable(o_block_last))
        else $error("output item changed while stalled");

    // a byte that is not the last of its block means the scan is still running
    a_no_fill_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_block_last |-> !o_in_ready)
        else $error("input ready while a block is still being sent");

    // new output bytes only come from the scan, never while filling
    a_emit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("output item appeared while filling");

    // the block comes out of reset ready to fill
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_in_ready && !o_out_valid)
        else $error("not ready to fill after reset");

endmodule

bind block_transposition_decoder btd_checker u_btd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_plain_byte (o_plain_byte),
    .o_block_last (o_block_last)
);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for block_transposition_decoder: directed rows, then random phases
// of block size and key, with random stalls on both sides; depends on btd_pkg and the rtl

module tb_top;
    import btd_pkg::*;

    localparam int DRAIN_CYCLES = 2 * MAX_BLOCK + 8;
    localparam int RANDOM_ITEMS = 196;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        logic [BYTE_W-1:0] plain;
        logic              blk_last;
    } t_plain_item;

    typedef enum logic {ROW_WRITE, ROW_BYTE} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} t_chk_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_cfg_idx          reg_idx;
        logic [63:0]       value;
        t_chk_kind         chk;
        logic [BYTE_W-1:0] exp_plain;
        logic              exp_last;
    } t_dir_row;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // block ports
    logic                  in_valid    = 1'b0;
    logic [BYTE_W-1:0]     cipher_byte = '0;
    logic                  out_ready   = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic [BYTE_W-1:0]     plain_byte;
    logic                  block_last;
    logic                  cfg_ready;

    block_transposition_decoder u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_cipher_byte (cipher_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_plain_byte  (plain_byte),
        .o_block_last  (block_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // decoder state as the testbench tracks it
    logic [BSIZE_W-1:0] model_bsize = BSIZE_RESET;
    logic [KEY_W-1:0]   model_key   = KEY_RESET;
    logic [BYTE_W-1:0]  model_store [MAX_BLOCK];
    int unsigned        model_fill  = 0;

    t_plain_item expected_plain [$];
    t_plain_item step_out [$];

    bit burst_mode  = 1'b0;
    int fail_count  = 0;
    int items_sent  = 0;
    int plain_seen  = 0;
    int cfg_writes  = 0;

    // directed rows: typed results only where obvious
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_WRITE, CFG_BLOCK_SIZE, 64'd1,                  CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h00,                 CHK_ONE,   8'h00, 1'b1},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'hFF,                 CHK_ONE,   8'hFF, 1'b1},
        '{ROW_WRITE, CFG_BLOCK_SIZE, 64'd0,                  CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'hA5,                 CHK_ONE,   8'hA5, 1'b1},
        '{ROW_WRITE, CFG_KEY_ORDER,  64'hFFFF_FFFF_FFFF_FFFF, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h3C,                 CHK_NONE,  8'h00, 1'b0},
        '{ROW_WRITE, CFG_BLOCK_SIZE, 64'd4,                  CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, CFG_KEY_ORDER,  64'h0000_0000_0000_0123, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h11,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h22,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h33,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h44,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, CFG_KEY_ORDER,  64'hFFFF_FFFF_FFFF_F101, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h5A,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'hC3,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h0F,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'hF0,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, CFG_KEY_ORDER,  64'hFEDC_BA98_7654_3210, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h01,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h02,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h03,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, CFG_BLOCK_SIZE, 64'd2,                  CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BYTE,  CFG_BLOCK_SIZE, 64'h04,                 CHK_MODEL, 8'h00, 1'b0},
        '{ROW_WRITE, CFG_BLOCK_SIZE, 64'd31,                 CHK_MODEL, 8'h00, 1'b0}
    };

    // store one cipher byte and, on a full block, list the plain bytes in rank order
    function automatic void untranspose_byte(input logic [BYTE_W-1:0] b);
        int unsigned size;
        int unsigned pos;
        t_plain_item tail;
        size = int'(model_bsize);
        if (size == 0) begin
            size = 1;
        end else if (size > MAX_BLOCK) begin
            size = MAX_BLOCK;
        end
        pos = model_fill;
        model_store[pos] = b;
        step_out.delete();
        if (pos + 1 < size) begin
            model_fill = pos + 1;
        end else begin
            for (int unsigned rank = 0; rank < size; rank++) begin
                for (int unsigned z = 0; z < size; z++) begin
                    if (int'(model_key[4*z +: 4]) == rank) begin
                        tail.plain    = model_store[z];
                        tail.blk_last = 1'b0;
                        step_out = {step_out, tail};
                    end
                end
            end
            // mark the final byte of the block
            if (step_out.size() > 0) begin
                step_out[step_out.size() - 1].blk_last = 1'b1;
            end
            model_fill = 0;
        end
    endfunction

    // send one cipher byte after a random gap; predict at acceptance
    task automatic send_cipher(input logic [BYTE_W-1:0] b, input t_chk_kind chk,
                               input t_plain_item typed);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cipher_byte <= b;
        do @(posedge clk); while (!in_ready);
        untranspose_byte(b);
        case (chk)
            CHK_MODEL: begin
                foreach (step_out[i]) expected_plain = {expected_plain, step_out[i]};
            end
            CHK_ONE: begin
                expected_plain = {expected_plain, typed};
            end
            default: ;
        endcase
        items_sent++;
        @(negedge clk);
    endtask

    // register write once the block has drained
    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_plain.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BLOCK_SIZE: model_bsize = value[BSIZE_W-1:0];
            CFG_KEY_ORDER:  model_key   = value;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // output side: random stall before each item
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            gap = burst_mode ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // compare each accepted plain byte with the oldest expectation
    always @(posedge clk) begin : check_plain
        t_plain_item want;
        if (rst_n && out_valid && out_ready) begin
            plain_seen++;
            if (expected_plain.size() == 0) begin
                $error("unexpected item: plain_byte %02h block_last %0b", plain_byte, block_last);
                fail_count++;
            end else begin
                want = expected_plain.pop_front();
                if (plain_byte !== want.plain) begin
                    $error("plain_byte mismatch: expected %02h, actual %02h",
                           want.plain, plain_byte);
                    fail_count++;
                end
                if (block_last !== want.blk_last) begin
                    $error("block_last mismatch: expected %0b, actual %0b",
                           want.blk_last, block_last);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_dir_row          r;
        t_plain_item       typed;
        int                size;
        int                eff;
        int                n;
        int                pick;
        int                j;
        int                tmp;
        int                base;
        int                perm [MAX_BLOCK];
        logic [KEY_W-1:0]  key;
        logic [63:0]       size_word;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows
        for (int i = 0; i < DIR_ROWS; i++) begin
            r = dir_rows[i];
            if (r.kind == ROW_WRITE) begin
                write_cfg(r.reg_idx, r.value);
            end else begin
                typed.plain    = r.exp_plain;
                typed.blk_last = r.exp_last;
                send_cipher(r.value[BYTE_W-1:0], r.chk, typed);
            end
        end

        // random phases: new size and key, then a run of bytes that may end mid-block
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            case (pick)
                6:       size = 0;
                7:       size = MAX_BLOCK;
                8:       size = $urandom_range(MAX_BLOCK + 1, 31);
                9:       size = $urandom_range(7, MAX_BLOCK - 1);
                default: size = $urandom_range(1, 6);
            endcase
            eff = (size == 0) ? 1 : ((size > MAX_BLOCK) ? MAX_BLOCK : size);

            // shuffled ranks for the live positions
            for (int z = 0; z < MAX_BLOCK; z++) perm[z] = z;
            for (int i = eff - 1; i > 0; i--) begin
                j       = $urandom_range(0, i);
                tmp     = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            key  = {$urandom, $urandom};
            pick = $urandom_range(0, 7);
            if (pick < 6) begin
                for (int z = 0; z < eff; z++) key[4*z +: 4] = 4'(perm[z]);
                // one broken rank: repeated or oversized
                if (pick == 5) begin
                    j = $urandom_range(0, eff - 1);
                    key[4*j +: 4] = 4'($urandom_range(0, 15));
                end
            end else if (pick == 7) begin
                key = ($urandom_range(0, 1) == 1) ? '1 : '0;
            end

            size_word = {$urandom, $urandom};
            size_word[BSIZE_W-1:0] = BSIZE_W'(size);
            write_cfg(CFG_BLOCK_SIZE, size_word);
            write_cfg(CFG_KEY_ORDER, key);

            n = $urandom_range(2, 3 * eff + 2);
            if (n > RANDOM_ITEMS - (items_sent - base)) begin
                n = RANDOM_ITEMS - (items_sent - base);
            end
            repeat (n) send_cipher(BYTE_W'($urandom_range(0, 255)), CHK_MODEL, '0);
        end

        // drain
        in_valid <= 1'b0;
        burst_mode = 1'b0;
        while (expected_plain.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d cipher bytes, %0d plain bytes checked, %0d register writes",
                 items_sent, plain_seen, cfg_writes);
        $display("block sizes 0 to 31 with clamping, shuffled, repeated, oversized and flat keys");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(2_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
